FILE: src/kgn_pkg.sv
package kgn_pkg;

  localparam int IMG_WIDTH  = 320;
  localparam int IMG_HEIGHT = 240;
  localparam int MAX_RADIUS = 8;

  localparam int MAP_W  = IMG_WIDTH + 2 * MAX_RADIUS;
  localparam int MAP_H  = IMG_HEIGHT + 2 * MAX_RADIUS;
  localparam int ROW_AW = $clog2(MAP_H);
  localparam int COL_W  = $clog2(MAP_W);
  localparam int SPAN_W = 2 * MAX_RADIUS + 1;

  // Widths fixed by the item and register fields.
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int RANK_W  = 10;
  localparam int RAD_W   = 4;
  localparam int MAXP_W  = 11;
  localparam int CFG_AW  = 1;
  localparam int DIM_W   = 13;
  localparam int IN_TW   = 24;
  localparam int OUT_TW  = 32;

  localparam int LIMIT_CAP = 1024;

  localparam logic [CFG_AW-1:0] REG_RADIUS     = 1'b0;
  localparam logic [CFG_AW-1:0] REG_MAX_POINTS = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic [MAXP_W-1:0] max_points;
  } cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [MAP_W-1:0]  wr_data;
    logic              clear;
  } map_req_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_MARK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

FILE: src/keypoint_grid_nms.sv
// A point outside the image, or one that arrives once the frame is full, gets no map read.
// A point whose cell is already taken takes one map read and a bit test.
// A free point takes one read, one bit test, 2r+1 row updates and an emit step;
// nine map rows at the default radius of four; a stalled result holds it in the emit step.
// The result of a kept point is registered in the emit step, after the last row update.
// Reset clears the map at once through per-row valid bits and sets radius 4, limit 1000.
module keypoint_grid_nms (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kgn_pkg::IN_TW-1:0]         s_tdata,   // pos_x[8:0], pos_y[16:9], zeros
  input  logic                              s_tlast,   // frame_last
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kgn_pkg::OUT_TW-1:0]        m_tdata,   // kept_x[8:0], kept_y[16:9],
                                                       // kept_rank[26:17], zeros
  input  logic                              cfg_we,
  input  logic [kgn_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [kgn_pkg::MAXP_W-1:0]        cfg_wdata
);

  kgn_pkg::cfg_t     cfg;
  kgn_pkg::map_req_t map_req;

  logic [kgn_pkg::MAP_W-1:0]  map_rdata;
  logic [kgn_pkg::X_W-1:0]    kept_x;
  logic [kgn_pkg::Y_W-1:0]    kept_y;
  logic [kgn_pkg::RANK_W-1:0] kept_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius     <= kgn_pkg::RAD_W'(4);
      cfg.max_points <= kgn_pkg::MAXP_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kgn_pkg::REG_RADIUS:     cfg.radius     <= cfg_wdata[kgn_pkg::RAD_W-1:0];
        kgn_pkg::REG_MAX_POINTS: cfg.max_points <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  kgn_map_mem u_map (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .rd_row (map_rdata)
  );

  kgn_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[kgn_pkg::X_W-1:0]),
    .in_y      (s_tdata[kgn_pkg::X_W+kgn_pkg::Y_W-1:kgn_pkg::X_W]),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (kept_x),
    .out_y     (kept_y),
    .out_rank  (kept_rank),
    .map_req   (map_req),
    .map_rdata (map_rdata)
  );

  assign m_tdata = {(kgn_pkg::OUT_TW - kgn_pkg::RANK_W - kgn_pkg::Y_W - kgn_pkg::X_W)'(0),
                    kept_rank, kept_y, kept_x};

endmodule

FILE: src/kgn_map_mem.sv
module kgn_map_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  kgn_pkg::map_req_t             req,
  output logic [kgn_pkg::MAP_W-1:0]     rd_row
);

  logic [kgn_pkg::MAP_W-1:0] mem [kgn_pkg::MAP_H];
  logic [kgn_pkg::MAP_H-1:0] row_valid;
  logic [kgn_pkg::MAP_W-1:0] rd_data;
  logic                      rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  // A row that has not been written since the last clear reads as all free.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid <= row_valid[req.rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

FILE: src/kgn_seq.sv
module kgn_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  kgn_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [kgn_pkg::X_W-1:0]        in_x,
  input  logic [kgn_pkg::Y_W-1:0]        in_y,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kgn_pkg::X_W-1:0]        out_x,
  output logic [kgn_pkg::Y_W-1:0]        out_y,
  output logic [kgn_pkg::RANK_W-1:0]     out_rank,
  output kgn_pkg::map_req_t              map_req,
  input  logic [kgn_pkg::MAP_W-1:0]      map_rdata
);

  kgn_pkg::state_t state;
  kgn_pkg::state_t state_next;

  logic [kgn_pkg::X_W-1:0]    x_q;
  logic [kgn_pkg::Y_W-1:0]    y_q;
  logic                       last_q;
  logic                       keep_q;
  logic [kgn_pkg::RAD_W-1:0]  r_q;
  logic [kgn_pkg::ROW_AW-1:0] pr_q;
  logic [kgn_pkg::COL_W-1:0]  pc_q;
  logic [kgn_pkg::ROW_AW-1:0] row_q;
  logic [kgn_pkg::ROW_AW-1:0] row_end;
  logic [kgn_pkg::MAP_W-1:0]  mask_q;
  logic [kgn_pkg::MAXP_W-1:0] count;
  logic                       full;

  logic                       accept;
  logic [kgn_pkg::RAD_W-1:0]  r_eff;
  logic [kgn_pkg::DIM_W-1:0]  xd;
  logic [kgn_pkg::DIM_W-1:0]  yd;
  logic [kgn_pkg::DIM_W-1:0]  rd;
  logic                       in_img;
  logic                       ignored;
  logic                       interior;
  logic [kgn_pkg::ROW_AW-1:0] pr_in;
  logic [kgn_pkg::COL_W-1:0]  pc_in;
  logic                       cell_free;
  logic [kgn_pkg::ROW_AW-1:0] row_lo;
  logic [kgn_pkg::SPAN_W-1:0] span;
  logic [kgn_pkg::MAP_W-1:0]  mask_next;
  logic [kgn_pkg::MAXP_W-1:0] limit;
  logic [kgn_pkg::MAXP_W-1:0] count_inc;
  logic                       out_free;
  logic                       emit_go;
  logic                       finish;

  assign in_ready = (state == kgn_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  assign r_eff = (cfg.radius > kgn_pkg::RAD_W'(kgn_pkg::MAX_RADIUS)) ?
                 kgn_pkg::RAD_W'(kgn_pkg::MAX_RADIUS) : cfg.radius;

  assign xd = kgn_pkg::DIM_W'(in_x);
  assign yd = kgn_pkg::DIM_W'(in_y);
  assign rd = kgn_pkg::DIM_W'(r_eff);

  assign in_img   = (xd < kgn_pkg::DIM_W'(kgn_pkg::IMG_WIDTH)) &&
                    (yd < kgn_pkg::DIM_W'(kgn_pkg::IMG_HEIGHT));
  assign ignored  = full || !in_img;
  assign interior = (yd >= rd) && (yd + rd < kgn_pkg::DIM_W'(kgn_pkg::IMG_HEIGHT)) &&
                    (xd >= rd) && (xd + rd < kgn_pkg::DIM_W'(kgn_pkg::IMG_WIDTH));

  assign pr_in = kgn_pkg::ROW_AW'(yd + kgn_pkg::DIM_W'(kgn_pkg::MAX_RADIUS));
  assign pc_in = kgn_pkg::COL_W'(xd + kgn_pkg::DIM_W'(kgn_pkg::MAX_RADIUS));

  assign cell_free = !map_rdata[pc_q];
  assign row_lo    = pr_q - kgn_pkg::ROW_AW'(r_q);

  // The square's row mask: 2r+1 ones, placed so that the lowest sits at pc - r.
  always_comb begin
    for (int i = 0; i < kgn_pkg::SPAN_W; i++) begin
      span[i] = (i <= 2 * int'(r_q));
    end
    mask_next = kgn_pkg::MAP_W'(span) << (pc_q - kgn_pkg::COL_W'(r_q));
  end

  always_comb begin
    if (cfg.max_points == '0) begin
      limit = kgn_pkg::MAXP_W'(1);
    end else if (cfg.max_points > kgn_pkg::MAXP_W'(kgn_pkg::LIMIT_CAP)) begin
      limit = kgn_pkg::MAXP_W'(kgn_pkg::LIMIT_CAP);
    end else begin
      limit = cfg.max_points;
    end
  end

  assign count_inc = count + kgn_pkg::MAXP_W'(1);
  assign out_free  = !out_valid || out_ready;
  assign emit_go   = (state == kgn_pkg::S_EMIT) && keep_q && out_free;
  assign finish    = (state == kgn_pkg::S_EMIT) && (!keep_q || out_free);

  always_comb begin
    map_req.rd_en   = 1'b0;
    map_req.rd_addr = pr_in;
    map_req.wr_en   = 1'b0;
    map_req.wr_addr = row_q;
    map_req.wr_data = map_rdata | mask_q;
    map_req.clear   = 1'b0;
    state_next      = state;
    unique case (state)
      kgn_pkg::S_IDLE: begin
        if (accept) begin
          if (ignored) begin
            map_req.clear = in_last;
          end else begin
            map_req.rd_en = 1'b1;
            state_next    = kgn_pkg::S_CHECK;
          end
        end
      end
      kgn_pkg::S_CHECK: begin
        if (cell_free) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = row_lo;
          state_next      = kgn_pkg::S_MARK;
        end else begin
          map_req.clear = last_q;
          state_next    = kgn_pkg::S_IDLE;
        end
      end
      kgn_pkg::S_MARK: begin
        // Write back the row just read while fetching the next one.
        map_req.wr_en   = 1'b1;
        map_req.rd_addr = row_q + kgn_pkg::ROW_AW'(1);
        if (row_q == row_end) begin
          state_next = kgn_pkg::S_EMIT;
        end else begin
          map_req.rd_en = 1'b1;
        end
      end
      kgn_pkg::S_EMIT: begin
        if (finish) begin
          map_req.clear = last_q;
          state_next    = kgn_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kgn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kgn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q    <= in_x;
      y_q    <= in_y;
      last_q <= in_last;
      keep_q <= interior;
      r_q    <= r_eff;
      pr_q   <= pr_in;
      pc_q   <= pc_in;
    end
    if (state == kgn_pkg::S_CHECK) begin
      mask_q  <= mask_next;
      row_q   <= row_lo;
      row_end <= pr_q + kgn_pkg::ROW_AW'(r_q);
    end else if (state == kgn_pkg::S_MARK) begin
      row_q <= row_q + kgn_pkg::ROW_AW'(1);
    end
  end

  // Frame bookkeeping; a frame end clears the count in the same edge as the map.
  always_ff @(posedge clk) begin
    if (rst || map_req.clear) begin
      count <= '0;
      full  <= 1'b0;
    end else if (emit_go) begin
      count <= count_inc;
      full  <= (count_inc >= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_x    <= x_q;
      out_y    <= y_q;
      out_rank <= count[kgn_pkg::RANK_W-1:0];
    end
  end

endmodule

FILE: src/kgn_checker.sv
module kgn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kgn_pkg::OUT_TW-1:0]    m_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A kept point always lies inside the image.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[kgn_pkg::X_W-1:0] < kgn_pkg::X_W'(kgn_pkg::IMG_WIDTH)) &&
                 (m_tdata[kgn_pkg::X_W+kgn_pkg::Y_W-1:kgn_pkg::X_W] <
                  kgn_pkg::Y_W'(kgn_pkg::IMG_HEIGHT)))
    else $error("kept point outside the image");

  // Reset leaves no result pending and the input side ready.
  assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("state not cleared by reset");

  // A result can only appear after some item has been accepted.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready || $past(!s_tready) || $past(s_tvalid, 2))
    else $error("result without an accepted item");

endmodule

bind keypoint_grid_nms kgn_checker u_kgn_checker (.*);

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int N_RANDOM      = 1850;
  localparam int N_PLAN        = 31;
  // Settle time: twice what a free point at the largest radius needs.
  localparam int SETTLE_CYCLES = 4 * kgn_pkg::MAX_RADIUS + 8;
  localparam int MAX_IDLE      = 17;

  typedef enum logic {ROW_POINT, ROW_REGS} row_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_KEPT} chk_t;

  typedef struct packed {
    logic [kgn_pkg::RANK_W-1:0] rank;
    logic [kgn_pkg::Y_W-1:0]    y;
    logic [kgn_pkg::X_W-1:0]    x;
  } kept_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [kgn_pkg::X_W-1:0]    x;
    logic [kgn_pkg::Y_W-1:0]    y;
    logic                       last;
    chk_t                       chk;
    logic [kgn_pkg::RANK_W-1:0] rank;
    logic [kgn_pkg::RAD_W-1:0]  rad;
    logic [kgn_pkg::MAXP_W-1:0] maxp;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [kgn_pkg::IN_TW-1:0]   s_tdata;
  logic                        s_tlast;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [kgn_pkg::OUT_TW-1:0]  m_tdata;
  logic                        cfg_we;
  logic [kgn_pkg::CFG_AW-1:0]  cfg_addr;
  logic [kgn_pkg::MAXP_W-1:0]  cfg_wdata;

  // Predictor state.
  logic [kgn_pkg::MAP_W-1:0]   taken_rows [kgn_pkg::MAP_H];
  int                          kept_total;
  bit                          pred_full;
  logic [kgn_pkg::RAD_W-1:0]   reg_radius;
  logic [kgn_pkg::MAXP_W-1:0]  reg_max_points;

  kept_t                kept_q [$];
  plan_row_t            plan [N_PLAN];

  bit                   running = 1'b0;
  bit                   steady  = 1'b0;
  int                   n_cycles  = 0;
  int                   n_errors  = 0;
  int                   n_checked = 0;
  int                   n_points  = 0;

  keypoint_grid_nms dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("no progress: stopped after %0d cycles", n_cycles);
      $display("keypoint_grid_nms verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic void clear_map();
    foreach (taken_rows[i]) taken_rows[i] = '0;
    kept_total = 0;
    pred_full  = 1'b0;
  endfunction

  function automatic void queue_kept(input kept_t item);
    kept_q = {kept_q, item};
  endfunction

  // Greedy suppression of one point; returns 1 when the point is emitted.
  function automatic bit suppress_point(input logic [kgn_pkg::X_W-1:0] x,
                                        input logic [kgn_pkg::Y_W-1:0] y,
                                        input logic last, output kept_t res);
    int r, lim, xi, yi, i, j;
    bit hit;
    hit = 1'b0;
    res = '0;
    xi  = int'(x);
    yi  = int'(y);
    r   = (reg_radius > kgn_pkg::RAD_W'(kgn_pkg::MAX_RADIUS)) ? kgn_pkg::MAX_RADIUS :
          int'(reg_radius);
    lim = (reg_max_points == '0) ? 1 :
          (reg_max_points > kgn_pkg::MAXP_W'(kgn_pkg::LIMIT_CAP)) ? kgn_pkg::LIMIT_CAP :
          int'(reg_max_points);
    if (!pred_full && xi < kgn_pkg::IMG_WIDTH && yi < kgn_pkg::IMG_HEIGHT &&
        !taken_rows[kgn_pkg::ROW_AW'(yi + kgn_pkg::MAX_RADIUS)]
                   [kgn_pkg::COL_W'(xi + kgn_pkg::MAX_RADIUS)]) begin
      // The pad equals the largest radius, so the square never leaves the map.
      for (i = yi + kgn_pkg::MAX_RADIUS - r; i <= yi + kgn_pkg::MAX_RADIUS + r; i++) begin
        for (j = xi + kgn_pkg::MAX_RADIUS - r; j <= xi + kgn_pkg::MAX_RADIUS + r; j++) begin
          taken_rows[kgn_pkg::ROW_AW'(i)][kgn_pkg::COL_W'(j)] = 1'b1;
        end
      end
      if (yi >= r && yi + r < kgn_pkg::IMG_HEIGHT &&
          xi >= r && xi + r < kgn_pkg::IMG_WIDTH) begin
        res.x    = x;
        res.y    = y;
        res.rank = kept_total[kgn_pkg::RANK_W-1:0];
        hit      = 1'b1;
        kept_total++;
        if (kept_total >= lim) pred_full = 1'b1;
      end
    end
    if (last) clear_map();
    return hit;
  endfunction

  function automatic plan_row_t pt(input int x, input int y, input bit last, input chk_t chk,
                                   input int rank);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_POINT;
    row.x    = kgn_pkg::X_W'(x);
    row.y    = kgn_pkg::Y_W'(y);
    row.last = last;
    row.chk  = chk;
    row.rank = kgn_pkg::RANK_W'(rank);
    return row;
  endfunction

  function automatic plan_row_t regs(input int rad, input int maxp);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_REGS;
    row.chk  = CHK_NONE;
    row.rad  = kgn_pkg::RAD_W'(rad);
    row.maxp = kgn_pkg::MAXP_W'(maxp);
    return row;
  endfunction

  task automatic push_point(input logic [kgn_pkg::X_W-1:0] x,
                            input logic [kgn_pkg::Y_W-1:0] y,
                            input logic last, output bit hit, output kept_t res);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(kgn_pkg::IN_TW - kgn_pkg::X_W - kgn_pkg::Y_W){1'b0}}, y, x};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_points++;
    hit = suppress_point(x, y, last, res);
  endtask

  // Wait until every expected item is out and a point with no result has finished too.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [kgn_pkg::RAD_W-1:0] rad,
                            input logic [kgn_pkg::MAXP_W-1:0] maxp);
    cfg_we    <= 1'b1;
    cfg_addr  <= kgn_pkg::REG_RADIUS;
    cfg_wdata <= {{(kgn_pkg::MAXP_W - kgn_pkg::RAD_W){1'b0}}, rad};
    @(posedge clk);
    cfg_addr  <= kgn_pkg::REG_MAX_POINTS;
    cfg_wdata <= maxp;
    @(posedge clk);
    cfg_we         <= 1'b0;
    reg_radius     = rad;
    reg_max_points = maxp;
  endtask

  // Output side: random back-pressure and in-order checking.
  initial begin
    int    stall;
    kept_t want;
    kept_t got;
    m_tready = 1'b0;
    wait (running);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.x    = m_tdata[kgn_pkg::X_W-1:0];
      got.y    = m_tdata[kgn_pkg::X_W+kgn_pkg::Y_W-1:kgn_pkg::X_W];
      got.rank = m_tdata[kgn_pkg::X_W+kgn_pkg::Y_W+kgn_pkg::RANK_W-1:kgn_pkg::X_W+kgn_pkg::Y_W];
      if (kept_q.size() == 0) begin
        if (n_errors < 10)
          $display("%0t: unexpected item x=%0d y=%0d rank=%0d", $realtime,
                   got.x, got.y, got.rank);
        n_errors++;
      end else begin
        want = kept_q.pop_front();
        n_checked++;
        if (got.x !== want.x || got.y !== want.y || got.rank !== want.rank) begin
          if (n_errors < 10)
            $display("%0t: mismatch, expected x=%0d y=%0d rank=%0d, got x=%0d y=%0d rank=%0d",
                     $realtime, want.x, want.y, want.rank, got.x, got.y, got.rank);
          n_errors++;
        end
      end
    end
  end

  initial begin
    bit                         hit;
    bit                         live;
    kept_t                      res;
    kept_t                      typed;
    int                         phase, n_frames, len, n, pick, tx, ty, px, py, n_counted;
    logic [kgn_pkg::X_W-1:0]    x;
    logic [kgn_pkg::Y_W-1:0]    y;
    logic [kgn_pkg::RAD_W-1:0]  rad;
    logic [kgn_pkg::MAXP_W-1:0] maxp;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = kgn_pkg::REG_RADIUS;
    cfg_wdata = '0;
    clear_map();
    reg_radius     = 4'd4;
    reg_max_points = 11'd1000;

    plan = '{
      // Reset settings: radius 4, limit 1000.
      pt(0, 0, 0, CHK_NONE, 0),        // corner: marks but lies on the border
      pt(4, 4, 0, CHK_MODEL, 0),
      pt(160, 120, 0, CHK_KEPT, 0),
      pt(162, 121, 0, CHK_NONE, 0),    // inside the square of the last kept point
      pt(319, 239, 0, CHK_NONE, 0),
      pt(320, 10, 0, CHK_NONE, 0),     // outside the image
      pt(511, 255, 0, CHK_NONE, 0),
      pt(10, 240, 0, CHK_NONE, 0),
      pt(4, 235, 1, CHK_KEPT, 1),
      regs(0, 1000),                   // radius zero: every free point goes out
      pt(0, 0, 0, CHK_KEPT, 0),
      pt(0, 0, 0, CHK_NONE, 0),
      pt(1, 0, 0, CHK_KEPT, 1),
      pt(319, 239, 1, CHK_KEPT, 2),
      regs(15, 2047),                  // radius saturates, limit caps
      pt(8, 8, 0, CHK_KEPT, 0),
      pt(7, 100, 0, CHK_NONE, 0),
      pt(16, 8, 0, CHK_NONE, 0),
      pt(17, 8, 0, CHK_KEPT, 1),
      pt(311, 231, 1, CHK_KEPT, 2),
      regs(1, 0),                      // a zero limit acts as one
      pt(50, 50, 0, CHK_KEPT, 0),
      pt(100, 100, 0, CHK_NONE, 0),    // frame already full
      pt(200, 200, 1, CHK_NONE, 0),
      pt(100, 100, 1, CHK_KEPT, 0),
      regs(2, 1024),
      pt(100, 100, 0, CHK_KEPT, 0),
      regs(0, 1024),                   // radius change inside a frame keeps the map
      pt(103, 100, 0, CHK_MODEL, 0),
      pt(102, 100, 1, CHK_MODEL, 0),
      pt(100, 100, 0, CHK_KEPT, 0)
    };

    repeat (2) @(posedge clk);
    rst     <= 1'b0;
    running = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGS) begin
        drain();
        write_regs(plan[i].rad, plan[i].maxp);
      end else begin
        push_point(plan[i].x, plan[i].y, plan[i].last, hit, res);
        case (plan[i].chk)
          CHK_MODEL: if (hit) queue_kept(res);
          CHK_KEPT: begin
            typed.x    = plan[i].x;
            typed.y    = plan[i].y;
            typed.rank = plan[i].rank;
            queue_kept(typed);
          end
          default: ;
        endcase
      end
    end

    phase     = 0;
    n_counted = 0;
    px        = 160;
    py        = 120;
    while (n_points < N_RANDOM) begin
      case (phase)
        0: begin rad = 4'd0;  maxp = 11'd2047; end
        1: begin rad = 4'd8;  maxp = 11'd1024; end
        2: begin rad = 4'd15; maxp = 11'd1;    end
        3: begin rad = 4'd0;  maxp = 11'd520;  end   // one long frame that fills up
        4: begin rad = 4'd9;  maxp = 11'd0;    end
        default: begin
          rad  = kgn_pkg::RAD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) :
                                                              $urandom_range(0, 8));
          maxp = kgn_pkg::MAXP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) :
                                                               $urandom_range(7, 2047));
        end
      endcase
      drain();
      write_regs(rad, maxp);
      steady   = (phase % 5 == 3);
      n_frames = (phase == 3) ? 1 : $urandom_range(1, 4);
      repeat (n_frames) begin
        len = (phase == 3) ? 600 :
              ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        for (n = 0; n < len; n++) begin
          pick = $urandom_range(0, 15);
          if (pick == 0) begin
            tx = $urandom_range(kgn_pkg::IMG_WIDTH, 511);
            ty = $urandom_range(0, 255);
          end else if (pick == 1) begin
            tx = $urandom_range(0, 511);
            ty = $urandom_range(kgn_pkg::IMG_HEIGHT, 255);
          end else if (pick <= 6) begin
            // Close to the previous point, so suppression squares get hit.
            tx = px + int'($urandom_range(0, 20)) - 10;
            ty = py + int'($urandom_range(0, 20)) - 10;
            if (tx < 0) tx = 0;
            if (tx > kgn_pkg::IMG_WIDTH - 1) tx = kgn_pkg::IMG_WIDTH - 1;
            if (ty < 0) ty = 0;
            if (ty > kgn_pkg::IMG_HEIGHT - 1) ty = kgn_pkg::IMG_HEIGHT - 1;
          end else if (pick == 7) begin
            tx = $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(310, 319);
            ty = $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(230, 239);
          end else begin
            tx = $urandom_range(0, kgn_pkg::IMG_WIDTH - 1);
            ty = $urandom_range(0, kgn_pkg::IMG_HEIGHT - 1);
          end
          x    = kgn_pkg::X_W'(tx);
          y    = kgn_pkg::Y_W'(ty);
          live = !pred_full && tx < kgn_pkg::IMG_WIDTH && ty < kgn_pkg::IMG_HEIGHT;
          push_point(x, y, n == len - 1, hit, res);
          if (hit) queue_kept(res);
          if (live) begin
            n_counted++;
            px = tx;
            py = ty;
          end
        end
      end
      phase++;
    end
    steady = 1'b0;

    drain();
    $display("%0d points sent, %0d of them live in random frames across %0d register settings",
             n_points, n_counted, phase);
    $display("%0d kept items checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("keypoint_grid_nms verification clean");
    end else begin
      $display("keypoint_grid_nms verification failed");
    end
    $finish;
  end

endmodule
